// ===== hdl/multi_button_debounce_long_press_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer
// Shared concurrent-check forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication
`define MBDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MBDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mbdlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdlp_pkg
// Types and constants shared by the debouncer lanes, merge stage and top.
// ----------------------------------------------------------------------------
package mbdlp_pkg;

  localparam int LEVEL_W   = 8;
  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;
  localparam int CNT_W     = 4;
  localparam int IDX_W     = 3;
  localparam int MASK_W    = 8;
  localparam int CFG_A_W   = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [MS_W-1:0]  DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_W-1:0]  LONG_PRESS_RST = 16'd1000;
  localparam logic [CNT_W-1:0] COUNT_RST      = 4'd8;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_kind_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_BUTTON_COUNT = 2'd2
  } cfg_reg_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    ev_kind_t kind;
    logic     held;
    logic     cand_held;
  } lane_stat_t;

  // Merged outcome of one poll
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [IDX_W-1:0]  index;
    ev_kind_t          kind;
  } result_t;

endpackage

// ===== hdl/mbdlp_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdlp_lane
// Debounce and long-press state of one button; evaluates a candidate update
// and applies it only when the merge stage says the poll reached this button.
// ----------------------------------------------------------------------------
module mbdlp_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          eval,
  input  logic                          commit,
  input  logic                          raw,
  input  logic [mbdlp_pkg::TIME_W-1:0]  now_ms,
  input  logic [mbdlp_pkg::MS_W-1:0]    settle_ms,
  input  logic [mbdlp_pkg::MS_W-1:0]    hold_ms,
  output mbdlp_pkg::lane_stat_t         stat
);

  logic                         last_r, stable_r, pend_r, held_r, lrep_r;
  logic [mbdlp_pkg::TIME_W-1:0] start_r, press_r;

  logic                         cand_last_r, cand_stable_r, cand_pend_r;
  logic                         cand_held_r, cand_lrep_r;
  logic [mbdlp_pkg::TIME_W-1:0] cand_start_r, cand_press_r;
  mbdlp_pkg::ev_kind_t          cand_kind_r;

  logic                         cand_last_nxt, cand_stable_nxt, cand_pend_nxt;
  logic                         cand_held_nxt, cand_lrep_nxt;
  logic [mbdlp_pkg::TIME_W-1:0] cand_start_nxt, cand_press_nxt;
  mbdlp_pkg::ev_kind_t          cand_kind_nxt;

  logic [mbdlp_pkg::TIME_W-1:0] settle_age, hold_age;

  assign settle_age = now_ms - start_r;
  assign hold_age   = now_ms - press_r;

  always_comb begin
    cand_last_nxt   = last_r;
    cand_stable_nxt = stable_r;
    cand_pend_nxt   = pend_r;
    cand_held_nxt   = held_r;
    cand_lrep_nxt   = lrep_r;
    cand_start_nxt  = start_r;
    cand_press_nxt  = press_r;
    cand_kind_nxt   = mbdlp_pkg::EV_NONE;
    if (raw != last_r) begin
      // level moved: restart settling
      cand_last_nxt  = raw;
      cand_pend_nxt  = 1'b1;
      cand_start_nxt = now_ms;
    end else begin
      if (pend_r && (settle_age >= {16'd0, settle_ms})) begin
        cand_pend_nxt = 1'b0;
        if (raw != stable_r) begin
          cand_stable_nxt = raw;
          cand_lrep_nxt   = 1'b0;
          cand_held_nxt   = !raw;
          if (!raw) begin
            cand_press_nxt = now_ms;
            cand_kind_nxt  = mbdlp_pkg::EV_PRESS;
          end else begin
            cand_kind_nxt  = mbdlp_pkg::EV_RELEASE;
          end
        end
      end
      if ((cand_kind_nxt == mbdlp_pkg::EV_NONE) && held_r && !lrep_r &&
          (hold_age >= {16'd0, hold_ms})) begin
        cand_lrep_nxt = 1'b1;
        cand_kind_nxt = mbdlp_pkg::EV_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      cand_last_r   <= cand_last_nxt;
      cand_stable_r <= cand_stable_nxt;
      cand_pend_r   <= cand_pend_nxt;
      cand_held_r   <= cand_held_nxt;
      cand_lrep_r   <= cand_lrep_nxt;
      cand_start_r  <= cand_start_nxt;
      cand_press_r  <= cand_press_nxt;
      cand_kind_r   <= cand_kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b1;
      stable_r <= 1'b1;
      pend_r   <= 1'b0;
      held_r   <= 1'b0;
      lrep_r   <= 1'b0;
      start_r  <= '0;
      press_r  <= '0;
    end else if (commit) begin
      last_r   <= cand_last_r;
      stable_r <= cand_stable_r;
      pend_r   <= cand_pend_r;
      held_r   <= cand_held_r;
      lrep_r   <= cand_lrep_r;
      start_r  <= cand_start_r;
      press_r  <= cand_press_r;
    end
  end

  assign stat.kind      = cand_kind_r;
  assign stat.held      = held_r;
  assign stat.cand_held = cand_held_r;

endmodule

// ===== hdl/mbdlp_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdlp_merge
// Picks the lowest active lane with an event, marks the lanes the poll
// reached, and builds the held mask as it stands after the poll.
// ----------------------------------------------------------------------------
module mbdlp_merge #(
  parameter int MAX_BUTTONS = 8
) (
  input  logic [mbdlp_pkg::CNT_W-1:0] button_count,
  input  mbdlp_pkg::lane_stat_t       stat [MAX_BUTTONS],
  output logic [MAX_BUTTONS-1:0]      commit_mask,
  output mbdlp_pkg::result_t          res
);

  localparam int WIN_W = ($clog2(MAX_BUTTONS) > mbdlp_pkg::IDX_W) ?
                         $clog2(MAX_BUTTONS) : mbdlp_pkg::IDX_W;

  logic [MAX_BUTTONS-1:0] active;
  logic [WIN_W-1:0]       win;
  logic                   found;
  mbdlp_pkg::ev_kind_t    kind;

  for (genvar g = 0; g < MAX_BUTTONS; g++) begin : g_act
    assign active[g] = ({28'd0, button_count} > 32'(g));
  end

  // Lanes up to and including the first event are reached; later ones hold
  always_comb begin
    found       = 1'b0;
    win         = '0;
    kind        = mbdlp_pkg::EV_NONE;
    commit_mask = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      commit_mask[i] = active[i] && !found;
      if (active[i] && !found && (stat[i].kind != mbdlp_pkg::EV_NONE)) begin
        found = 1'b1;
        win   = WIN_W'(i);
        kind  = stat[i].kind;
      end
    end
  end

  for (genvar g = 0; g < mbdlp_pkg::MASK_W; g++) begin : g_mask
    if (g < MAX_BUTTONS) begin : g_real
      assign res.mask[g] = active[g] &&
                           (commit_mask[g] ? stat[g].cand_held : stat[g].held);
    end else begin : g_none
      assign res.mask[g] = 1'b0;
    end
  end

  assign res.index = win[mbdlp_pkg::IDX_W-1:0];
  assign res.kind  = kind;

endmodule

// ===== hdl/multi_button_debounce_long_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debounce_long_press
// Per-button debounce with press, release and long-press events.
// ----------------------------------------------------------------------------
// Each input item is one poll: a raw active-low level per button and a
// wrapping millisecond stamp. Every button has its own lane that works out
// its update in parallel; a merge stage then takes the first event in index
// order, commits the lanes up to it and leaves the rest untouched. An item
// passes through capture, lane evaluation, and merge and commit in turn;
// the next item is accepted in the cycle after the merge, so a new poll is
// not taken until the last one has been merged and committed. A result
// that is not taken holds the merge stage. There is no clearing pass after
// reset. Configuration registers: 0 debounce time, 1 long-press time,
// 2 button count; index 3 is ignored.
// ----------------------------------------------------------------------------
`include "multi_button_debounce_long_press_defines.svh"

module multi_button_debounce_long_press #(
  parameter int MAX_BUTTONS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // levels [7:0], now_ms [39:8]
  input  logic [mbdlp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // button_index [2:0], held_mask [10:3], zero [15:11]
  output logic [mbdlp_pkg::OUT_DATA_W-1:0]    out_tdata,
  // event_kind [1:0]
  output logic [1:0]                          out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [mbdlp_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [mbdlp_pkg::MS_W-1:0]          cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_MERGE
  } state_t;

  state_t                          state_r;
  logic                            out_valid_r;
  mbdlp_pkg::result_t              out_res_r;
  logic [mbdlp_pkg::LEVEL_W-1:0]   levels_r;
  logic [mbdlp_pkg::TIME_W-1:0]    now_r;
  logic [mbdlp_pkg::MS_W-1:0]      debounce_r, long_press_r;
  logic [mbdlp_pkg::CNT_W-1:0]     count_r;

  mbdlp_pkg::lane_stat_t           stat [MAX_BUTTONS];
  logic [MAX_BUTTONS-1:0]          commit_mask;
  mbdlp_pkg::result_t              merge_res;
  logic                            in_fire, lane_eval, merge_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign lane_eval  = (state_r == S_EVAL);
  assign merge_fire = (state_r == S_MERGE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= mbdlp_pkg::DEBOUNCE_RST;
      long_press_r <= mbdlp_pkg::LONG_PRESS_RST;
      count_r      <= mbdlp_pkg::COUNT_RST;
    end else if (cfg_we) begin
      unique case (mbdlp_pkg::cfg_reg_t'(cfg_addr))
        mbdlp_pkg::REG_DEBOUNCE:     debounce_r   <= cfg_wdata;
        mbdlp_pkg::REG_LONG_PRESS:   long_press_r <= cfg_wdata;
        mbdlp_pkg::REG_BUTTON_COUNT: count_r      <= cfg_wdata[mbdlp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      levels_r <= in_tdata[mbdlp_pkg::LEVEL_W-1:0];
      now_r    <= in_tdata[mbdlp_pkg::IN_DATA_W-1:mbdlp_pkg::LEVEL_W];
    end
    if (merge_fire) begin
      out_res_r <= merge_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (merge_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE:  if (in_fire) state_r <= S_EVAL;
        S_EVAL:  state_r <= S_MERGE;
        S_MERGE: if (merge_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < MAX_BUTTONS; g++) begin : g_lane
    logic raw;
    if (g < mbdlp_pkg::LEVEL_W) begin : g_pin
      assign raw = levels_r[g];
    end else begin : g_nopin
      // no level bit: reads as not pressed
      assign raw = 1'b1;
    end

    mbdlp_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .eval      (lane_eval),
      .commit    (merge_fire && commit_mask[g]),
      .raw       (raw),
      .now_ms    (now_r),
      .settle_ms (debounce_r),
      .hold_ms   (long_press_r),
      .stat      (stat[g])
    );
  end

  mbdlp_merge #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_merge (
    .button_count (count_r),
    .stat         (stat),
    .commit_mask  (commit_mask),
    .res          (merge_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'd0, out_res_r.mask, out_res_r.index};

  `MBDLP_ASSERT_NEXT(a_accept_to_eval, in_fire, state_r == S_EVAL, "item not evaluated")
  `MBDLP_ASSERT_NEXT(a_merge_to_out, merge_fire, out_valid_r, "merged result not presented")
  `MBDLP_ASSERT_NOW(a_none_index_zero,
    out_valid_r && (out_res_r.kind == mbdlp_pkg::EV_NONE), out_res_r.index == '0,
    "no event but nonzero button index")
  `MBDLP_ASSERT_NOW(a_mask_in_count, out_valid_r, (out_res_r.mask >> count_r) == '0,
    "held mask has bits beyond button count")
  `MBDLP_ASSERT_NOW(a_commit_only_merge, lane_eval, !merge_fire, "eval and commit overlap")

endmodule
